### hdl/assert_macros.svh
// Assertion macros for the checker file of the face emitter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, skip while reset is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check an implication whose consequence is checked in the cycle after it.
`define ASSERT_NEXT(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

### hdl/svfe_pkg.sv
// Types and constants of the sprite voxel face emitter.
// Used by every module of the block; no dependencies.
package svfe_pkg;

  localparam int MAX_WIDTH_DFLT = 256;
  localparam int FACE_COUNT = 5;

  localparam logic [8:0]  IMAGE_WIDTH_RST = 9'd256;
  localparam logic [7:0]  ALPHA_THR_RST   = 8'd200;
  localparam logic [20:0] VTX_PER_FACE    = 21'd4;

  typedef enum logic [2:0] {
    FACE_FRONT  = 3'd0,
    FACE_LEFT   = 3'd1,
    FACE_RIGHT  = 3'd2,
    FACE_BOTTOM = 3'd3,
    FACE_TOP    = 3'd4
  } face_e;

  typedef enum logic {
    REG_IMAGE_WIDTH     = 1'b0,
    REG_ALPHA_THRESHOLD = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] alpha;
    logic       frame_start;
  } in_word_t;

  typedef struct packed {
    face_e       face_kind;
    logic [7:0]  pixel_col;
    logic [7:0]  pixel_row;
    logic [20:0] first_vertex;
    logic        last_face;
  } out_word_t;

  // One voxel's pending faces: bit k of the mask set means face k is shown.
  typedef struct packed {
    logic [FACE_COUNT-1:0] mask;
    logic [7:0]            col;
    logic [7:0]            row;
    logic [20:0]           vbase;
  } job_t;

endpackage

### hdl/sprite_voxel_face_emitter_unit.sv
// Sprite voxel face emitter, top level. Depends on svfe_pkg, svfe_front,
// svfe_job_fifo and svfe_emit.
// Path: a voxel's job is queued when the word that completes its neighborhood
//   (the pixel below it in the next row) is taken, then loaded into the emitter.
// Throughput: one input word per cycle while the job queue has room; one
//   record per cycle out while not stalled, one per face (1..5) of a voxel.
// Reset (async, active low): line buffer fill count, counters and queue clear;
//   image_width reads 256 and alpha_threshold 200.
module sprite_voxel_face_emitter_unit
  import svfe_pkg::*;
#(
  parameter int MaxWidth = MAX_WIDTH_DFLT
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_data_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_data_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0] image_width_q;
  logic [7:0] alpha_thr_q;
  reg_idx_e   reg_idx;

  logic       step;
  logic       job_push, job_pop, job_valid, job_full;
  job_t       job_in, job_out;

  // Register file: two words, index taken from the word address bit.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:     prdata = {23'd0, image_width_q};
      REG_ALPHA_THRESHOLD: prdata = {24'd0, alpha_thr_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= IMAGE_WIDTH_RST;
      alpha_thr_q   <= ALPHA_THR_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:     image_width_q <= pwdata[8:0];
        REG_ALPHA_THRESHOLD: alpha_thr_q   <= pwdata[7:0];
        default:             ;
      endcase
    end
  end

  // Hold the input only when the job queue is full; the queue parts the
  // input side from output stalls.
  assign in_stall_o = job_full;
  assign step       = in_valid_i && !in_stall_o;

  // Classify each word and update the rolling line buffers.
  svfe_front #(
    .MaxWidth(MaxWidth)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .image_width_i    (image_width_q),
    .alpha_threshold_i(alpha_thr_q),
    .step_i           (step),
    .word_i           (in_data_i),
    .job_valid_o      (job_push),
    .job_o            (job_in)
  );

  // Queue voxels that show at least one face.
  svfe_job_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .data_i (job_in),
    .pop_i  (job_pop),
    .valid_o(job_valid),
    .full_o (job_full),
    .data_o (job_out)
  );

  // Serialize faces, lowest face kind first.
  svfe_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .pop_o      (job_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

### hdl/svfe_front.sv
// Pixel classifier: line buffers, position counters and face mask per voxel.
// Depends on svfe_pkg.
module svfe_front
  import svfe_pkg::*;
#(
  parameter int MaxWidth = MAX_WIDTH_DFLT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [8:0] image_width_i,
  input  logic [7:0] alpha_threshold_i,
  input  logic       step_i,
  input  in_word_t   word_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  localparam int ColW = $clog2(MaxWidth);
  localparam int WidW = (ColW + 1 > 10) ? ColW + 1 : 10;
  localparam logic [WidW-1:0] MaxW = WidW'(MaxWidth);

  typedef struct packed {
    logic prev;
    logic cur;
  } line_t;

  // Columns are always written in order from 0 within a frame, so the entries
  // written since the frame began form a prefix [0, fill); the rest read as 0.
  line_t             line_q [MaxWidth];
  line_t             mem_a_q;
  logic              mem_b_q;
  line_t             wr_q;
  logic              a_mem_q, a_mem_d;
  logic              b_mem_q, b_mem_d;
  logic              b_byp_q, b_byp_d;
  logic [ColW:0]     fill_q, fill_d, fill_base;
  logic              left_q;
  logic [ColW-1:0]   col_q, col_d;
  logic [8:0]        row_q, row_d;
  logic [20:0]       vtx_q, vtx_d;

  logic [WidW-1:0]   iw_ext, eff_w;
  logic [ColW-1:0]   x;
  logic [ColW:0]     xp1, x_wide, addr_a, addr_b;
  logic [ColW-1:0]   idx_a, idx_b;
  logic [8:0]        rc, row_m1;
  logic [20:0]       vbase;
  line_t             here, here_raw, wr;
  logic              nxt_cur, nxt_raw;
  logic              incoming, left_opq, right_opq, show;
  logic [FACE_COUNT-1:0] mask;
  logic [2:0]        n_faces;
  logic [ColW+7:0]   x_ext;

  always_comb begin
    iw_ext = WidW'(image_width_i);
    if (iw_ext < WidW'(2)) begin
      eff_w = WidW'(2);
    end else if (iw_ext > MaxW) begin
      eff_w = MaxW;
    end else begin
      eff_w = iw_ext;
    end

    // A new frame restarts at pixel (0, 0) with empty buffers.
    x      = word_i.frame_start ? '0 : col_q;
    rc     = word_i.frame_start ? '0 : row_q;
    vbase  = word_i.frame_start ? '0 : vtx_q;
    xp1    = {1'b0, x} + (ColW + 1)'(1);
    x_wide = {1'b0, x};

    // Column x and x+1 were fetched when the previous word was taken.
    here_raw = a_mem_q ? mem_a_q : '0;
    nxt_raw  = b_byp_q ? wr_q.cur : (b_mem_q && mem_b_q);
    here     = word_i.frame_start ? '0 : here_raw;
    nxt_cur  = !word_i.frame_start && nxt_raw;

    incoming  = !word_i.kind && (word_i.alpha >= alpha_threshold_i);
    left_opq  = (x != '0) && left_q && !word_i.frame_start;
    right_opq = (WidW'(xp1) < eff_w) && nxt_cur;
    show      = (rc != '0) && here.cur;

    mask = '0;
    if (show) begin
      mask[FACE_FRONT]  = 1'b1;
      mask[FACE_LEFT]   = !left_opq;
      mask[FACE_RIGHT]  = !right_opq;
      mask[FACE_BOTTOM] = !here.prev;
      mask[FACE_TOP]    = !incoming;
    end
    n_faces = 3'($countones(mask));

    row_m1 = rc - 9'd1;
    x_ext  = (ColW + 8)'(x);

    job_o.mask  = mask;
    job_o.col   = x_ext[7:0];
    job_o.row   = row_m1[7:0];
    job_o.vbase = vbase + 21'd1;
    job_valid_o = step_i && show;

    vtx_d = vbase + {16'd0, n_faces, 2'b00};
    if (WidW'(xp1) >= eff_w) begin
      col_d = '0;
      row_d = rc + 9'd1;
    end else begin
      col_d = xp1[ColW-1:0];
      row_d = rc;
    end

    // Roll the window: current row bit moves down, new bit takes its place.
    wr        = '{prev: here.cur, cur: incoming};
    fill_base = word_i.frame_start ? '0 : fill_q;
    fill_d    = (xp1 > fill_base) ? xp1 : fill_base;

    // Fetch the next column and its right neighbor. The next column never
    // equals x; its neighbor does when a two-pixel row wraps, so forward it.
    addr_a  = {1'b0, col_d};
    addr_b  = addr_a + (ColW + 1)'(1);
    idx_a   = addr_a[ColW-1:0];
    idx_b   = addr_b[ColW-1:0];
    a_mem_d = (addr_a < fill_d);
    b_byp_d = (addr_b == x_wide);
    b_mem_d = !b_byp_d && (addr_b < fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      a_mem_q <= 1'b0;
      b_mem_q <= 1'b0;
      b_byp_q <= 1'b0;
      fill_q  <= '0;
      left_q  <= 1'b0;
      col_q   <= '0;
      row_q   <= '0;
      vtx_q   <= '0;
    end else if (step_i) begin
      wr_q    <= wr;
      a_mem_q <= a_mem_d;
      b_mem_q <= b_mem_d;
      b_byp_q <= b_byp_d;
      fill_q  <= fill_d;
      left_q  <= here.cur;
      col_q   <= col_d;
      row_q   <= row_d;
      vtx_q   <= vtx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      line_q[x] <= wr;
      mem_a_q   <= line_q[idx_a];
      mem_b_q   <= line_q[idx_b].cur;
    end
  end

endmodule

### hdl/svfe_job_fifo.sv
// Two-entry queue of voxel jobs between the classifier and the emitter.
// Depends on svfe_pkg.
module svfe_job_fifo
  import svfe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output logic valid_o,
  output logic full_o,
  output job_t data_o
);

  job_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

### hdl/svfe_emit.sv
// Face emitter: sends one face record per cycle while the output is not stalled, from the current voxel job.
// Depends on svfe_pkg.
module svfe_emit
  import svfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o
);

  logic [FACE_COUNT-1:0] rem_q;
  logic [7:0]            col_q, row_q;
  logic [20:0]           vtx_q;

  logic [2:0]            sel;
  logic [FACE_COUNT-1:0] low, rest;
  logic                  take, last, done;

  always_comb begin
    sel = 3'd0;
    for (int k = FACE_COUNT - 1; k >= 0; k--) begin
      if (rem_q[k]) begin
        sel = 3'(k);
      end
    end
    low  = FACE_COUNT'(1) << sel;
    rest = rem_q & ~low;
    last = (rest == '0);

    out_valid_o             = (rem_q != '0);
    out_data_o.face_kind    = face_e'(sel);
    out_data_o.pixel_col    = col_q;
    out_data_o.pixel_row    = row_q;
    out_data_o.first_vertex = vtx_q;
    out_data_o.last_face    = last;

    take  = out_valid_o && !out_stall_i;
    done  = !out_valid_o || (take && last);
    pop_o = done && job_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (pop_o) begin
      rem_q <= job_i.mask;
    end else if (take) begin
      rem_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      col_q <= job_i.col;
      row_q <= job_i.row;
      vtx_q <= job_i.vbase;
    end else if (take) begin
      vtx_q <= vtx_q + VTX_PER_FACE;
    end
  end

endmodule

### hdl/svfe_checker.sv
// Port-level checks of the face emitter and their bind to the top level.
// Depends on svfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module svfe_checker
  import svfe_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_data_o
);

  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output word changed")
  `ASSERT_CLK(a_vtx_align, out_valid_o |-> (out_data_o.first_vertex[1:0] == 2'b01), "first vertex not on a face boundary")
  `ASSERT_NEXT(a_same_voxel, out_valid_o && !out_stall_i && !out_data_o.last_face, out_valid_o && out_data_o.pixel_col == $past(out_data_o.pixel_col) && out_data_o.pixel_row == $past(out_data_o.pixel_row) && out_data_o.face_kind > $past(out_data_o.face_kind) && out_data_o.first_vertex == $past(out_data_o.first_vertex) + VTX_PER_FACE, "voxel records broken")
  `ASSERT_NEXT(a_front_first, out_valid_o && !out_stall_i && out_data_o.last_face, !out_valid_o || out_data_o.face_kind == FACE_FRONT, "voxel does not open with front face")

endmodule

bind sprite_voxel_face_emitter_unit svfe_checker u_svfe_checker (.*);

### test/sprite_voxel_face_emitter_unit_tb.sv
// Testbench of the sprite voxel face emitter: a directed table, then random sprites,
// with every face record checked against an in-bench face predictor.
// Depends on svfe_pkg and sprite_voxel_face_emitter_unit.
module sprite_voxel_face_emitter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svfe_pkg::*;

  localparam int LINE_MAX      = 256;
  localparam int REPORT_MAX    = 10;
  localparam int SETTLE_CYCLES = 8;     // settle time after the last predicted record
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off, fills the job queue
  // About 310 words, at most 5 records each, 26% receiver idling and sender gaps,
  // plus the hold-off and bus cycles, all well inside the limit.
  localparam int CYCLE_LIMIT   = 50000;

  // Clock, reset and DUT ports. Every input is known from time zero.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_data_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  always #5 clk_i = ~clk_i;

  sprite_voxel_face_emitter_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Face predictor state: a rolling two-line window of opacity bits.
  // older_line holds row y up to the current column and row y-1 past it;
  // newer_line holds the arriving row up to the current column and row y past it.
  bit          older_line [LINE_MAX];
  bit          newer_line [LINE_MAX];
  bit [7:0]    col_pos;
  bit [8:0]    row_pos;
  bit [20:0]   vtx_used;
  bit [8:0]    cfg_width  = IMAGE_WIDTH_RST;
  bit [7:0]    cfg_thresh = ALPHA_THR_RST;
  out_word_t   faces_due [$];

  int          mismatches = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  bit          src_gaps = 1'b1;
  bit          snk_gaps = 1'b1;

  // Directed words; faces >= 0 is the record count read straight off the sprite.
  typedef struct {
    bit       kind;
    bit [7:0] alpha;
    bit       frame_start;
    int       faces;
  } probe_t;

  // Directed part runs at width 3, threshold 128.
  probe_t probes [26] = '{
    '{1'b0, 8'd255, 1'b1, 0},   // row 0: stored only, nothing emitted
    '{1'b0, 8'd128, 1'b0, 0},   // alpha equal to threshold: opaque
    '{1'b0, 8'd127, 1'b0, 0},   // just below threshold: transparent
    '{1'b0, 8'd0,   1'b0, 4},   // voxel (0,0): front, left edge, bottom, top
    '{1'b0, 8'd255, 1'b0, 3},   // voxel (1,0): front, right, bottom
    '{1'b0, 8'd200, 1'b0, 0},   // voxel (2,0) transparent
    '{1'b1, 8'd255, 1'b0, 0},   // padding row, alpha ignored
    '{1'b1, 8'd255, 1'b0, 3},   // voxel (1,1): front, left, top
    '{1'b1, 8'd0,   1'b0, 4},   // voxel (2,1): front, right edge, bottom, top
    '{1'b0, 8'd255, 1'b0, 0},   // words after the padding row form a further row
    '{1'b0, 8'd0,   1'b0, 0},
    '{1'b0, 8'd255, 1'b0, 0},
    '{1'b1, 8'd0,   1'b0, -1},
    '{1'b1, 8'd255, 1'b0, -1},
    '{1'b0, 8'd255, 1'b1, 0},   // frame start in the middle of a row
    '{1'b0, 8'd0,   1'b1, 0},   // and again right after it
    '{1'b0, 8'd255, 1'b0, 0},
    '{1'b0, 8'd255, 1'b0, 0},
    '{1'b0, 8'd255, 1'b0, 0},   // voxel (0,0) transparent
    '{1'b0, 8'd255, 1'b0, 3},   // voxel (1,0): front, left, bottom
    '{1'b1, 8'd77,  1'b0, 4},   // voxel (2,0): front, right edge, bottom, top
    '{1'b1, 8'd0,   1'b0, 4},   // voxel (0,1): front, left edge, bottom, top
    '{1'b1, 8'd255, 1'b0, 3},   // voxel (1,1): front, right, top
    '{1'b1, 8'd9,   1'b0, 0},   // voxel (2,1) transparent
    '{1'b0, 8'd255, 1'b0, 0},   // leave the column at 2 so that the
    '{1'b0, 8'd255, 1'b0, 0}    // next width lands below it
  };

  typedef struct {
    logic [31:0] width_val;
    logic [31:0] thresh_val;
    int          words;
    int          p_opaque;
    bit          fresh;        // first word of the phase starts a frame
    int          min_rows;
    int          max_rows;
    int          noise;        // percent of words with random kind and frame start
    bit          gaps;
    bit          hold;
  } phase_t;

  phase_t phases [11] = '{
    '{32'd2,          32'd0,   24,  50, 1'b0, 1,   4,   8,  1'b1, 1'b0},
    '{32'd5,          32'd255, 24,  60, 1'b0, 1,   3,   8,  1'b1, 1'b0},
    '{32'd0,          32'd100, 20,  60, 1'b1, 1,   5,   8,  1'b1, 1'b0},
    '{32'd1,          32'd77,  20,  60, 1'b0, 1,   5,   8,  1'b1, 1'b0},
    '{32'd7,          32'd128, 30,  70, 1'b1, 1,   4,   8,  1'b0, 1'b0},
    '{32'd4,          32'd50,  24,  40, 1'b1, 1,   4,   10, 1'b1, 1'b0},
    '{32'd3,          32'd200, 24,  80, 1'b0, 1,   4,   8,  1'b1, 1'b0},
    '{32'd8,          32'd1,   60,  90, 1'b1, 2,   6,   0,  1'b0, 1'b1},
    '{32'd511,        32'd180, 14,  15, 1'b1, 1,   1,   2,  1'b1, 1'b0},
    '{32'hABCD_E002,  32'd30,  24,  50, 1'b1, 1,   4,   0,  1'b1, 1'b0},
    '{32'hFFFF_FF00,  32'd200, 20,  50, 1'b0, 1,   2,   8,  1'b1, 1'b0}
  };

  function automatic string face_str(out_word_t f);
    return $sformatf("face %0d col %0d row %0d vtx %0d last %0d",
                     f.face_kind, f.pixel_col, f.pixel_row, f.first_vertex, f.last_face);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endfunction

  function automatic void clear_sprite();
    foreach (older_line[i]) begin
      older_line[i] = 1'b0;
      newer_line[i] = 1'b0;
    end
    col_pos  = '0;
    row_pos  = '0;
    vtx_used = '0;
  endfunction

  // Clamp the width register to the line buffer range.
  function automatic int eff_width();
    int w;
    w = cfg_width;
    if (w < 2) w = 2;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  // Advance the window by one word, queue the faces of the voxel above it.
  function automatic int predict_faces(in_word_t wd);
    int        w;
    int        x;
    int        last_k;
    int        n;
    bit        opaque_in;
    bit [4:0]  show;
    bit [8:0]  row_lo;
    out_word_t rec;
    n = 0;
    last_k = 0;
    if (wd.frame_start) clear_sprite();
    w = eff_width();
    x = col_pos;
    opaque_in = !wd.kind && (wd.alpha >= cfg_thresh);
    if (row_pos != 0 && newer_line[x]) begin
      show[FACE_FRONT]  = 1'b1;
      show[FACE_LEFT]   = !(x > 0 && older_line[x-1]);
      show[FACE_RIGHT]  = !(x + 1 < w && newer_line[x+1]);
      show[FACE_BOTTOM] = !older_line[x];
      show[FACE_TOP]    = !opaque_in;
      for (int k = 0; k < FACE_COUNT; k++) if (show[k]) last_k = k;
      row_lo = row_pos - 9'd1;
      for (int k = 0; k < FACE_COUNT; k++) begin
        if (show[k]) begin
          rec.face_kind    = face_e'(k);
          rec.pixel_col    = x[7:0];
          rec.pixel_row    = row_lo[7:0];
          rec.first_vertex = vtx_used + 21'd1;
          rec.last_face    = (k == last_k);
          vtx_used = vtx_used + VTX_PER_FACE;
          faces_due.push_back(rec);
          n++;
        end
      end
    end
    older_line[x] = newer_line[x];
    newer_line[x] = opaque_in;
    if (x + 1 >= w) begin
      col_pos = '0;
      row_pos = row_pos + 9'd1;
    end else begin
      col_pos = 8'(x + 1);
    end
    return n;
  endfunction

  // Pick an alpha on either side of the threshold.
  function automatic logic [7:0] pick_alpha(int p_opaque);
    if (cfg_thresh == 0 || $urandom_range(0, 99) < p_opaque)
      return 8'($urandom_range(cfg_thresh, 255));
    return 8'($urandom_range(0, cfg_thresh - 1));
  endfunction

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: a long hold-off when requested, random idling otherwise.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= snk_gaps && ($urandom_range(0, 99) < 26);
    end
  end

  // Compare each accepted record with the oldest predicted one.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (faces_due.size() == 0) begin
        note_mismatch({"unexpected record: ", face_str(out_data_o)});
      end else begin
        want = faces_due.pop_front();
        if (out_data_o.face_kind !== want.face_kind ||
            out_data_o.pixel_col !== want.pixel_col ||
            out_data_o.pixel_row !== want.pixel_row ||
            out_data_o.first_vertex !== want.first_vertex ||
            out_data_o.last_face !== want.last_face)
          note_mismatch({"expected ", face_str(want), ", got ", face_str(out_data_o)});
      end
    end
  end

  // Read a register and compare; then return the bus to idle.
  task automatic apb_read_check(reg_idx_e r, logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata !== want)
      note_mismatch($sformatf("register %0d reads %0d, expected %0d", r, prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write a register, mirror it in the predictor, read it back.
  task automatic set_reg(reg_idx_e r, logic [31:0] v);
    logic [31:0] kept;
    kept = (r == REG_IMAGE_WIDTH) ? {23'd0, v[8:0]} : {24'd0, v[7:0]};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (r == REG_IMAGE_WIDTH) cfg_width = kept[8:0];
    else cfg_thresh = kept[7:0];
    apb_read_check(r, kept);
  endtask

  // Offer one word, hold it until accepted, then predict its records.
  task automatic send_word(in_word_t wd, output int n_faces);
    if (src_gaps) begin
      while ($urandom_range(0, 99) < 26) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i  <= wd;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    n_faces = predict_faces(wd);
  endtask

  // Drop valid, wait for every predicted record, let the pipeline settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (faces_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Well-formed sprites (rows, then a padding row) with random content,
  // some cut short, some words scrambled.
  task automatic send_sprites(int words, int w, int p_opaque, bit fresh,
                              int min_rows, int max_rows, int noise);
    int       sent;
    int       rows;
    int       total;
    int       cut;
    int       n;
    in_word_t wd;
    sent = 0;
    while (sent < words) begin
      rows  = $urandom_range(min_rows, max_rows);
      total = (rows + 1) * w;
      cut   = (noise > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
      for (int i = 0; i < cut && sent < words; i++) begin
        wd.kind        = (i >= rows * w);
        wd.alpha       = pick_alpha(p_opaque);
        wd.frame_start = (i == 0) && (fresh || sent != 0);
        if ($urandom_range(0, 99) < noise) begin
          wd.kind        = 1'($urandom_range(0, 1));
          wd.frame_start = ($urandom_range(0, 3) == 0);
        end
        send_word(wd, n);
        sent++;
      end
    end
  endtask

  initial begin
    int       n;
    int       w;
    in_word_t wd;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values.
    apb_read_check(REG_IMAGE_WIDTH, 32'd256);
    apb_read_check(REG_ALPHA_THRESHOLD, 32'd200);

    // Directed table.
    set_reg(REG_IMAGE_WIDTH, 32'd3);
    set_reg(REG_ALPHA_THRESHOLD, 32'd128);
    foreach (probes[i]) begin
      wd.kind        = probes[i].kind;
      wd.alpha       = probes[i].alpha;
      wd.frame_start = probes[i].frame_start;
      send_word(wd, n);
      if (probes[i].faces >= 0 && n != probes[i].faces)
        note_mismatch($sformatf("directed word %0d: %0d records predicted, %0d typed",
                                i, n, probes[i].faces));
    end

    // Random phases; each reconfigures only once the block has drained.
    foreach (phases[p]) begin
      wait_idle();
      set_reg(REG_IMAGE_WIDTH, phases[p].width_val);
      set_reg(REG_ALPHA_THRESHOLD, phases[p].thresh_val);
      src_gaps =  phases[p].gaps;
      snk_gaps <= phases[p].gaps;
      if (phases[p].hold) hold_left <= HOLD_CYCLES;
      w = eff_width();
      send_sprites(phases[p].words, w, phases[p].p_opaque, phases[p].fresh,
                   phases[p].min_rows, phases[p].max_rows, phases[p].noise);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
